/* rtl/sufr_pkg.sv */
// Shared types and constants for the SOME/IP-over-UART frame reassembler.
// Holds the input and result transfer structs and header layout constants.
// No dependencies.
package sufr_pkg;

    localparam int HEADER_BYTES = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_SERVICE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_MSG_TYPE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH        = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT      = 2'd3;

    localparam logic [15:0] RESET_EXPECTED_SERVICE  = 16'h1234;
    localparam logic [7:0]  RESET_EXPECTED_MSG_TYPE = 8'h02;
    localparam logic [5:0]  RESET_MAX_LENGTH        = 6'd32;
    localparam logic [15:0] RESET_IDLE_TIMEOUT      = 16'd50;

    // Header byte positions
    localparam int POS_METHOD   = 2;
    localparam int POS_LENGTH   = 4;
    localparam int POS_CONTROL  = 8;
    localparam int POS_MSG_TYPE = 14;

    // Length field counts the eight header bytes that follow it
    localparam logic [31:0] LENGTH_MIN = 32'd8;

    localparam logic [15:0] IDLE_TICKS_MAX = 16'hFFFF;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_ACCEPT  = 2'd0,
        STATUS_REJECT  = 2'd1,
        STATUS_BAD_LEN = 2'd2,
        STATUS_IDLE    = 2'd3
    } status_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] method_id;
        logic [7:0]  payload_byte;
    } out_item_t;

endpackage

/* rtl/someip_uart_frame_reassembler.sv */
// Top level of the SOME/IP-over-UART frame reassembler.
// Depends on sufr_pkg for transfer structs, codes and header constants.
//
// Each input transfer is one UART byte or one millisecond tick and is processed in the
// cycle it is accepted; a new transfer can be accepted every cycle while in_ready is high.
// Framer state (byte counter, captured header fields, idle counter) updates at the accept
// edge; a result goes to the output register, or to a one-entry skid register behind it if
// the output is stalled, so input continues while a result waits. in_ready drops only when
// both the output and the skid entry hold results, and returns once out_ready moves the
// skid entry into the output. Each accepted item yields zero or one result, in arrival order.
module someip_uart_frame_reassembler #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sufr_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sufr_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [sufr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sufr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sufr_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    logic [15:0]      expected_service_reg;
    logic [7:0]       expected_msg_type_reg;
    logic [5:0]       max_length_reg;
    logic [15:0]      idle_timeout_reg;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]      hdr_service_reg, hdr_service_next;
    logic [15:0]      hdr_method_reg, hdr_method_next;
    logic [31:0]      hdr_length_reg, hdr_length_next;
    logic [7:0]       hdr_msg_type_reg, hdr_msg_type_next;
    logic [7:0]       first_payload_reg, first_payload_next;
    logic [15:0]      idle_ticks_reg, idle_ticks_next;

    logic             out_valid_reg;
    out_item_t        out_data_reg;
    logic             skid_valid_reg;
    out_item_t        skid_data_reg;

    logic             accept;
    logic             res_valid;
    out_item_t        res_data;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      ticks_inc;
    logic [7:0]       frame_total;
    logic             len_bad;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_service_reg  <= RESET_EXPECTED_SERVICE;
            expected_msg_type_reg <= RESET_EXPECTED_MSG_TYPE;
            max_length_reg        <= RESET_MAX_LENGTH;
            idle_timeout_reg      <= RESET_IDLE_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_SERVICE:  expected_service_reg  <= cfg_data;
                CFG_EXPECTED_MSG_TYPE: expected_msg_type_reg <= cfg_data[7:0];
                CFG_MAX_LENGTH:        max_length_reg        <= cfg_data[5:0];
                CFG_IDLE_TIMEOUT:      idle_timeout_reg      <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign cnt_inc   = byte_count_reg + CNT_W'(1);
    assign ticks_inc = (idle_ticks_reg != IDLE_TICKS_MAX) ? idle_ticks_reg + 16'd1
                                                          : idle_ticks_reg;

    // Capture header fields at their byte positions
    always_comb
    begin
        hdr_service_next   = hdr_service_reg;
        hdr_method_next    = hdr_method_reg;
        hdr_length_next    = hdr_length_reg;
        hdr_msg_type_next  = hdr_msg_type_reg;
        first_payload_next = first_payload_reg;
        if (accept && in_data.req_type == REQ_BYTE
            && byte_count_reg < CNT_W'(BUFFER_BYTES))
        begin
            priority if (byte_count_reg < CNT_W'(POS_METHOD))
                hdr_service_next = {hdr_service_reg[7:0], in_data.rx_byte};
            else if (byte_count_reg < CNT_W'(POS_LENGTH))
                hdr_method_next = {hdr_method_reg[7:0], in_data.rx_byte};
            else if (byte_count_reg < CNT_W'(POS_CONTROL))
                hdr_length_next = {hdr_length_reg[23:0], in_data.rx_byte};
            else if (byte_count_reg == CNT_W'(POS_MSG_TYPE))
                hdr_msg_type_next = in_data.rx_byte;
            else if (byte_count_reg == CNT_W'(HEADER_BYTES))
                first_payload_next = in_data.rx_byte;
            else
                first_payload_next = first_payload_reg;
        end
    end

    assign len_bad     = (hdr_length_next < LENGTH_MIN)
                      || (hdr_length_next > {26'd0, max_length_reg});
    assign frame_total = {2'd0, hdr_length_next[5:0]} + 8'(HEADER_BYTES) - 8'(LENGTH_MIN);

    always_comb
    begin
        byte_count_next = byte_count_reg;
        idle_ticks_next = idle_ticks_reg;
        res_valid       = 1'b0;
        res_data        = '{status: STATUS_ACCEPT, method_id: 16'd0, payload_byte: 8'd0};
        if (accept)
        begin
            unique case (in_data.req_type)
                REQ_TICK:
                begin
                    if (byte_count_reg != '0)
                    begin
                        idle_ticks_next = ticks_inc;
                        if (ticks_inc > idle_timeout_reg)
                        begin
                            byte_count_next = '0;
                            idle_ticks_next = 16'd0;
                            res_valid       = 1'b1;
                            res_data.status = STATUS_IDLE;
                        end
                    end
                end
                REQ_BYTE:
                begin
                    idle_ticks_next = 16'd0;
                    if (byte_count_reg >= CNT_W'(BUFFER_BYTES))
                        byte_count_next = '0;
                    else
                    begin
                        byte_count_next = cnt_inc;
                        if (cnt_inc >= CNT_W'(HEADER_BYTES))
                        begin
                            if (len_bad)
                            begin
                                byte_count_next = '0;
                                res_valid       = 1'b1;
                                res_data.status = STATUS_BAD_LEN;
                            end
                            else if (8'(cnt_inc) >= frame_total)
                            begin
                                byte_count_next = '0;
                                res_valid       = 1'b1;
                                if (hdr_service_next == expected_service_reg
                                    && hdr_msg_type_next == expected_msg_type_reg)
                                begin
                                    res_data.status    = STATUS_ACCEPT;
                                    res_data.method_id = hdr_method_next;
                                    res_data.payload_byte =
                                        (hdr_length_next > LENGTH_MIN) ? first_payload_next
                                                                       : 8'd0;
                                end
                                else
                                    res_data.status = STATUS_REJECT;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            hdr_service_reg   <= '0;
            hdr_method_reg    <= '0;
            hdr_length_reg    <= '0;
            hdr_msg_type_reg  <= '0;
            first_payload_reg <= '0;
            idle_ticks_reg    <= '0;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            hdr_service_reg   <= hdr_service_next;
            hdr_method_reg    <= hdr_method_next;
            hdr_length_reg    <= hdr_length_next;
            hdr_msg_type_reg  <= hdr_msg_type_next;
            first_payload_reg <= first_payload_next;
            idle_ticks_reg    <= idle_ticks_next;
        end
    end

    // Output register with one-entry skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= res_valid;
            end
            else if (res_valid)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (res_valid)
                out_data_reg <= res_data;
        end
        else if (res_valid)
            skid_data_reg <= res_data;
    end

endmodule

/* rtl/sufr_checker.sv */
// Port-level checks for the SOME/IP-over-UART frame reassembler.
// Depends on sufr_pkg; bound to someip_uart_frame_reassembler below.
module sufr_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  sufr_pkg::in_item_t                in_data,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  sufr_pkg::out_item_t               out_data
);
    import sufr_pkg::*;

    // Input stalls only while a result is held at the output
    a_ready_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no result held");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result transfer changed");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STATUS_ACCEPT |->
            out_data.method_id == 16'd0 && out_data.payload_byte == 8'd0)
        else $error("non-accept result carries data");

    // A tick can only cause an idle timeout result
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.req_type == REQ_TICK && !out_valid |=>
            !out_valid || out_data.status == STATUS_IDLE)
        else $error("tick produced a result other than idle timeout");

endmodule

bind someip_uart_frame_reassembler sufr_checker u_sufr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* tb/sv/testbench.sv */
// Testbench for the SOME/IP-over-UART frame reassembler: directed and random byte/tick traffic.
// Holds a cycle-free framer predictor, a valid/ready driver, a stalling receiver and a checker.
// Depends on sufr_pkg and someip_uart_frame_reassembler.
`timescale 1ns / 1ps

module testbench;
    import sufr_pkg::*;

    localparam int FRAME_BUFFER_BYTES = 64;
    localparam int SHOWN_MISMATCHES   = 10;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor copy of the registers and the framer state
    logic [15:0] cfg_service;
    logic [7:0]  cfg_msg_type;
    logic [5:0]  cfg_max_len;
    logic [15:0] cfg_timeout;

    logic [6:0]  fr_count;
    logic [15:0] fr_service;
    logic [15:0] fr_method;
    logic [31:0] fr_length;
    logic [7:0]  fr_msg_type;
    logic [7:0]  fr_first_payload;
    logic [15:0] fr_idle;

    out_item_t   pending_results[$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          burst_left     = 1;
    bit          steady_sender  = 1'b0;

    logic [15:0] stall_cycle = '0;
    logic [1:0]  stall_mode  = '0;

    someip_uart_frame_reassembler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1'b1;
        if (stall_cycle[5:0] == 6'd0)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= 1'($urandom_range(0, 1));
            2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= stall_cycle[3];
        endcase
    end

    task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
            $display({"mismatch (%s): expected status %0d method %h payload %h,",
                      " got status %0d method %h payload %h"},
                what, want.status, want.method_id, want.payload_byte,
                got.status, got.method_id, got.payload_byte);
    endtask

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                want = '0;
                note_mismatch("unexpected transfer", want, out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status != want.status)
                    note_mismatch("status", want, out_data);
                else if (out_data.method_id != want.method_id)
                    note_mismatch("method_id", want, out_data);
                else if (out_data.payload_byte != want.payload_byte)
                    note_mismatch("payload_byte", want, out_data);
            end
        end
    end

    function automatic void reset_framer_model();
        cfg_service      = RESET_EXPECTED_SERVICE;
        cfg_msg_type     = RESET_EXPECTED_MSG_TYPE;
        cfg_max_len      = RESET_MAX_LENGTH;
        cfg_timeout      = RESET_IDLE_TIMEOUT;
        fr_count         = '0;
        fr_service       = '0;
        fr_method        = '0;
        fr_length        = '0;
        fr_msg_type      = '0;
        fr_first_payload = '0;
        fr_idle          = '0;
    endfunction

    function automatic bit predict_framer(input in_item_t item, output out_item_t res);
        logic [31:0] total;
        res.status       = STATUS_ACCEPT;
        res.method_id    = '0;
        res.payload_byte = '0;
        if (item.req_type == REQ_TICK)
        begin
            if (fr_count == 0)
                return 1'b0;
            if (fr_idle != IDLE_TICKS_MAX)
                fr_idle = fr_idle + 1'b1;
            if (fr_idle > cfg_timeout)
            begin
                fr_count   = '0;
                fr_idle    = '0;
                res.status = STATUS_IDLE;
                return 1'b1;
            end
            return 1'b0;
        end
        fr_idle = '0;
        if (fr_count >= FRAME_BUFFER_BYTES)
        begin
            fr_count = '0;
            return 1'b0;
        end
        if (fr_count < POS_METHOD)
            fr_service = {fr_service[7:0], item.rx_byte};
        else if (fr_count < POS_LENGTH)
            fr_method = {fr_method[7:0], item.rx_byte};
        else if (fr_count < POS_CONTROL)
            fr_length = {fr_length[23:0], item.rx_byte};
        else if (fr_count == POS_MSG_TYPE)
            fr_msg_type = item.rx_byte;
        else if (fr_count == HEADER_BYTES)
            fr_first_payload = item.rx_byte;
        fr_count = fr_count + 1'b1;
        if (fr_count < HEADER_BYTES)
            return 1'b0;
        if (fr_length < LENGTH_MIN || fr_length > {26'd0, cfg_max_len})
        begin
            fr_count   = '0;
            res.status = STATUS_BAD_LEN;
            return 1'b1;
        end
        total = HEADER_BYTES + fr_length - LENGTH_MIN;
        if (fr_count < total)
            return 1'b0;
        fr_count = '0;
        if (fr_service == cfg_service && fr_msg_type == cfg_msg_type)
        begin
            res.method_id    = fr_method;
            res.payload_byte = (fr_length > LENGTH_MIN) ? fr_first_payload : 8'd0;
        end
        else
            res.status = STATUS_REJECT;
        return 1'b1;
    endfunction

    task automatic send_item(input in_item_t item);
        out_item_t res;
        int gap;
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (predict_framer(item, res))
            pending_results.push_back(res);
        burst_left--;
        if (burst_left <= 0 && !steady_sender)
        begin
            burst_left = $urandom_range(1, 32);
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_item_t item;
        item.req_type = REQ_BYTE;
        item.rx_byte  = b;
        send_item(item);
    endtask

    task automatic send_tick();
        in_item_t item;
        item.req_type = REQ_TICK;
        item.rx_byte  = 8'($urandom);
        send_item(item);
    endtask

    // Send bytes first..last of a frame; last < 0 runs to the point where the framer decides
    task automatic send_frame(input logic [15:0] svc, input logic [15:0] method,
                              input logic [31:0] len, input logic [7:0] msg,
                              input int first, input int last);
        int stop;
        int pos;
        logic [7:0] b;
        if (len >= LENGTH_MIN && len <= {26'd0, cfg_max_len})
            stop = HEADER_BYTES + int'(len) - int'(LENGTH_MIN) - 1;
        else
            stop = HEADER_BYTES - 1;
        if (last >= 0 && last < stop)
            stop = last;
        for (pos = first; pos <= stop; pos++)
        begin
            b = 8'($urandom);
            if (pos < POS_METHOD)
                b = (pos == 0) ? svc[15:8] : svc[7:0];
            else if (pos < POS_LENGTH)
                b = (pos == POS_METHOD) ? method[15:8] : method[7:0];
            else if (pos < POS_CONTROL)
                b = len[8 * (POS_CONTROL - 1 - pos) +: 8];
            else if (pos == POS_MSG_TYPE)
                b = msg;
            send_byte(b);
        end
    endtask

    task automatic flush_partial_frame();
        while (fr_count != 0 && cfg_timeout < 200)
            send_tick();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_EXPECTED_SERVICE:  cfg_service  = value;
            CFG_EXPECTED_MSG_TYPE: cfg_msg_type = value[7:0];
            CFG_MAX_LENGTH:        cfg_max_len  = value[5:0];
            default:               cfg_timeout  = value;
        endcase
        @(posedge clk);
    endtask

    task automatic test_default_frames();
        send_tick();
        send_frame(16'h1234, 16'hBEEF, 32'd12, 8'h02, 0, -1);
        send_frame(16'h1234, 16'h0001, 32'd8, 8'h02, 0, -1);
        send_frame(16'h1235, 16'h0002, 32'd9, 8'h02, 0, -1);
        send_frame(16'h1234, 16'h0003, 32'd10, 8'h01, 0, -1);
        send_frame(16'h1234, 16'h0004, 32'd7, 8'h02, 0, -1);
        send_frame(16'h1234, 16'h0005, 32'd33, 8'h02, 0, -1);
        send_frame(16'h1234, 16'h0006, 32'hFFFF_FFFF, 8'h02, 0, -1);
        send_frame(16'h1234, 16'hFFFF, 32'd32, 8'h02, 0, -1);
        send_frame(16'h1234, 16'h0000, 32'd0, 8'h02, 0, -1);
    endtask

    task automatic test_idle_timeout();
        send_frame(16'h1234, 16'h0010, 32'd12, 8'h02, 0, 4);
        repeat (50) send_tick();
        send_frame(16'h1234, 16'h0010, 32'd12, 8'h02, 5, 5);
        repeat (51) send_tick();
        send_frame(16'h1234, 16'h0011, 32'd20, 8'h02, 0, 17);
        repeat (51) send_tick();
        send_frame(16'h1234, 16'h0012, 32'd9, 8'h02, 0, -1);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_EXPECTED_SERVICE, 16'h0000);
        write_reg(CFG_EXPECTED_MSG_TYPE, 16'h0000);
        write_reg(CFG_MAX_LENGTH, 16'd8);
        write_reg(CFG_IDLE_TIMEOUT, 16'd1);
        send_frame(16'h0000, 16'h8001, 32'd8, 8'h00, 0, -1);
        send_frame(16'h0000, 16'h8002, 32'd9, 8'h00, 0, -1);
        send_frame(16'h0000, 16'h8003, 32'd8, 8'h00, 0, 6);
        send_tick();
        send_tick();
        write_reg(CFG_EXPECTED_SERVICE, 16'hFFFF);
        write_reg(CFG_EXPECTED_MSG_TYPE, 16'h00FF);
        write_reg(CFG_MAX_LENGTH, 16'd48);
        write_reg(CFG_IDLE_TIMEOUT, 16'hFFFF);
        send_frame(16'hFFFF, 16'h7FFF, 32'd48, 8'hFF, 0, -1);
        send_frame(16'hFFFF, 16'h7FFE, 32'd49, 8'hFF, 0, -1);
        send_frame(16'hFFFF, 16'h7FFD, 32'd8, 8'hFE, 0, -1);
    endtask

    task automatic test_max_timeout();
        steady_sender = 1'b1;
        send_frame(16'hFFFF, 16'h4242, 32'd10, 8'hFF, 0, 2);
        repeat (40) send_tick();
        send_frame(16'hFFFF, 16'h4242, 32'd10, 8'hFF, 3, -1);
        steady_sender = 1'b0;
        write_reg(CFG_IDLE_TIMEOUT, 16'd2);
        steady_sender = 1'b1;
        send_frame(16'hFFFF, 16'h4243, 32'd10, 8'hFF, 0, 2);
        repeat (3) send_tick();
        steady_sender = 1'b0;
    endtask

    task automatic test_random_traffic();
        int phase;
        int phase_start;
        int r;
        int n;
        int hi;
        logic [15:0] svc;
        logic [7:0]  msg;
        logic [31:0] len;
        for (phase = 0; phase < 6; phase++)
        begin
            svc = 16'($urandom);
            msg = 8'($urandom);
            if (phase == 3)
            begin
                svc = 16'hFFFF;
                msg = 8'hFF;
            end
            else if (phase == 4)
            begin
                svc = 16'h0000;
                msg = 8'h00;
            end
            write_reg(CFG_EXPECTED_SERVICE, svc);
            write_reg(CFG_EXPECTED_MSG_TYPE, {8'd0, msg});
            case (phase)
                1:       write_reg(CFG_MAX_LENGTH, 16'd8);
                2:       write_reg(CFG_MAX_LENGTH, 16'd48);
                default: write_reg(CFG_MAX_LENGTH, 16'($urandom_range(8, 48)));
            endcase
            case (phase)
                0:       write_reg(CFG_IDLE_TIMEOUT, 16'd1);
                5:       write_reg(CFG_IDLE_TIMEOUT, 16'hFFFF);
                default: write_reg(CFG_IDLE_TIMEOUT, 16'($urandom_range(2, 40)));
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 40)
            begin
                r = $urandom_range(0, 99);
                svc = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cfg_service;
                msg = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg_msg_type;
                hi = (cfg_max_len < 14) ? int'(cfg_max_len) : 14;
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, cfg_max_len)
                                                  : $urandom_range(8, hi);
                if (r < 60)
                    send_frame(svc, 16'($urandom), len, msg, 0, -1);
                else if (r < 70)
                begin
                    case ($urandom_range(0, 2))
                        0:       len = $urandom_range(0, 7);
                        1:       len = $urandom_range(int'(cfg_max_len) + 1, 63);
                        default: len = $urandom;
                    endcase
                    send_frame(svc, 16'($urandom), len, msg, 0, -1);
                end
                else if (r < 80)
                begin
                    send_frame(svc, 16'($urandom), len, msg, 0, $urandom_range(0, 20));
                    if ($urandom_range(0, 1) == 0)
                        wait_drained();
                    flush_partial_frame();
                end
                else if (r < 90)
                begin
                    n = $urandom_range(1, 5);
                    repeat (n) send_byte(8'($urandom));
                    flush_partial_frame();
                end
                else
                begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_tick();
                end
            end
        end
    endtask

    initial
    begin
        reset_framer_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_default_frames();
        test_idle_timeout();
        test_config_extremes();
        test_max_timeout();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/sufr_pkg.sv
rtl/someip_uart_frame_reassembler.sv
rtl/sufr_checker.sv
tb/sv/testbench.sv
